@@ design/tgcc_pkg.sv @@
`default_nettype none
package tgcc_pkg;

  localparam int DEN_W  = 16;
  localparam int QUO_W  = 40;
  localparam int NUM_W  = QUO_W + 1;
  localparam int STAGES = QUO_W;

  localparam logic [1:0] MODE_ORTHO = 2'd0;
  localparam logic [1:0] MODE_ISO   = 2'd1;
  localparam logic [1:0] MODE_STAG  = 2'd2;

  localparam logic REQ_T2W = 1'b0;
  localparam logic REQ_W2T = 1'b1;

  localparam logic [1:0] CFG_GRID_MODE = 2'd0;
  localparam logic [1:0] CFG_TILE_W    = 2'd1;
  localparam logic [1:0] CFG_TILE_H    = 2'd2;

  localparam logic [15:0] TILE_RST = 16'd8192;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] mq;
  } div_t;

  typedef struct packed {
    logic               req;
    logic [1:0]         mode;
    logic               negx;
    logic               negy;
    div_t               dx;
    div_t               dy;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [34:0] px;
    logic signed [33:0] py;
  } stage_t;

  // one restoring division step: next numerator bit in, one quotient bit out
  function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] d);
    logic [DEN_W:0] r;
    div_t           o;
    r = {s.rem, s.mq[QUO_W-1]};
    o.mq = {s.mq[QUO_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r = r - {1'b0, d};
      o.mq[0] = 1'b1;
    end
    o.rem = r[DEN_W-1:0];
    return o;
  endfunction

  function automatic logic [16:0] sat16(input logic signed [41:0] v);
    logic [16:0] o;
    if (v > 42'sd32767) begin
      o = {1'b1, 16'h7fff};
    end else if (v < -42'sd32768) begin
      o = {1'b1, 16'h8000};
    end else begin
      o = {1'b0, v[15:0]};
    end
    return o;
  endfunction

  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] o;
    if (v > 36'sd2147483647) begin
      o = {1'b1, 32'h7fff_ffff};
    end else if (v < -36'sd2147483648) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, v[31:0]};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ design/tile_grid_coordinate_convert.sv @@
// A word passes stg_r[0], the divider stage registers and the output registers.
// Throughput: one word per cycle; the 40-step bit-per-stage divider pipeline
// sets the depth, and the whole pipe holds while a result word is stalled.
// Reset: synchronous active-low rst_n clears all valid bits and loads
// grid_mode 0 and tile sizes 32.0.
`default_nettype none
module tile_grid_coordinate_convert import tgcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_tile_col,
  input  wire logic signed [15:0] in_tile_row,
  input  wire logic signed [31:0] in_world_x_in,
  input  wire logic signed [31:0] in_world_y_in,
  input  wire logic signed [31:0] in_org_x,
  input  wire logic signed [31:0] in_org_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_world_x_out,
  output logic signed [31:0]      out_world_y_out,
  output logic signed [15:0]      out_tile_col_out,
  output logic signed [15:0]      out_tile_row_out,
  output logic                    out_clipped
);

  logic [1:0]  grid_mode_r;
  logic [15:0] tile_w_r, tile_h_r;
  logic [15:0] dw, dh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_mode_r <= MODE_ORTHO;
      tile_w_r    <= TILE_RST;
      tile_h_r    <= TILE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_MODE: grid_mode_r <= cfg_wdata[1:0];
        CFG_TILE_W:    tile_w_r    <= cfg_wdata;
        CFG_TILE_H:    tile_h_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dw = (tile_w_r == 16'd0) ? 16'd1 : tile_w_r;
  assign dh = (tile_h_r == 16'd0) ? 16'd1 : tile_h_r;

  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // entry
  logic                    iso, stag;
  logic signed [16:0]      ax, ay, tws, ths;
  logic signed [33:0]      mx, my;
  logic signed [32:0]      lx, ly;
  logic signed [NUM_W-1:0] nx, ny;
  stage_t                  s_in;

  assign iso  = (grid_mode_r == MODE_ISO);
  assign stag = (grid_mode_r == MODE_STAG);
  assign tws  = $signed({1'b0, tile_w_r});
  assign ths  = $signed({1'b0, tile_h_r});
  assign ax   = iso ? 17'(in_tile_col) - 17'(in_tile_row) : 17'(in_tile_col);
  assign ay   = iso ? 17'(in_tile_col) + 17'(in_tile_row) : 17'(in_tile_row);
  assign mx   = ax * tws;
  assign my   = ay * ths;
  assign lx   = in_world_x_in - in_org_x;
  assign ly   = in_org_y - in_world_y_in;
  assign nx   = iso ? (NUM_W'(lx) <<< 8) : NUM_W'(lx);
  assign ny   = iso ? (NUM_W'(ly) <<< 8) : (stag ? (NUM_W'(ly) <<< 1) : NUM_W'(ly));

  always_comb begin
    s_in.req    = in_req_type;
    s_in.mode   = grid_mode_r;
    s_in.negx   = nx[NUM_W-1];
    s_in.negy   = ny[NUM_W-1];
    s_in.dx.rem = '0;
    s_in.dy.rem = '0;
    s_in.dx.mq  = nx[NUM_W-1] ? ~nx[QUO_W-1:0] : nx[QUO_W-1:0];
    s_in.dy.mq  = ny[NUM_W-1] ? ~ny[QUO_W-1:0] : ny[QUO_W-1:0];
    s_in.ox     = in_org_x;
    s_in.oy     = in_org_y;
    if (iso) begin
      s_in.px = 35'(mx >>> 1);
    end else if (stag) begin
      s_in.px = 35'(mx) + (in_tile_row[0] ? $signed({20'd0, tile_w_r[15:1]}) : 35'sd0);
    end else begin
      s_in.px = 35'(mx);
    end
    s_in.py = (iso || stag) ? (my >>> 1) : my;
  end

  // divider pipe
  stage_t        stg_r [0:STAGES];
  logic [STAGES:0] vld_r;

  function automatic stage_t stage_adv(input stage_t s, input logic [DEN_W-1:0] d_w,
                                       input logic [DEN_W-1:0] d_h);
    stage_t o;
    o    = s;
    o.dx = div_step(s.dx, d_w);
    o.dy = div_step(s.dy, d_h);
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= s_in;
      for (int k = 1; k <= STAGES; k++) begin
        stg_r[k] <= stage_adv(stg_r[k-1], dw, dh);
      end
    end
  end

  // finish
  stage_t             p;
  logic [QUO_W-1:0]   qxb, qyb;
  logic signed [41:0] qa, qb, col, row;
  logic [15:0]        rx;
  logic [16:0]        sc, sr;
  logic [32:0]        swx, swy;
  logic               t2w;

  assign p   = stg_r[STAGES];
  assign qxb = p.negx ? ~p.dx.mq : p.dx.mq;
  assign qyb = p.negy ? ~p.dy.mq : p.dy.mq;
  assign qa  = 42'($signed({p.negx, qxb}));
  assign qb  = 42'($signed({p.negy, qyb}));
  assign rx  = p.negx ? (dw - 16'd1 - p.dx.rem) : p.dx.rem;
  assign t2w = (p.req == REQ_T2W);

  always_comb begin
    case (p.mode)
      MODE_ISO: begin
        col = (qa + qb) >>> 8;
        row = (qb - qa) >>> 8;
      end
      MODE_STAG: begin
        row = qb;
        col = (qb[0] && ({rx, 1'b0} < {1'b0, tile_w_r})) ? qa - 42'sd1 : qa;
      end
      default: begin
        col = qa;
        row = qb;
      end
    endcase
  end

  assign sc  = sat16(col);
  assign sr  = sat16(row);
  assign swx = sat32(36'(p.ox) + 36'(p.px));
  assign swy = sat32(36'(p.oy) - 36'(p.py));

  logic signed [31:0] wx_r, wy_r;
  logic signed [15:0] tc_r, tr_r;
  logic               clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r   <= t2w ? swx[31:0] : '0;
      wy_r   <= t2w ? swy[31:0] : '0;
      tc_r   <= t2w ? '0 : sc[15:0];
      tr_r   <= t2w ? '0 : sr[15:0];
      clip_r <= t2w ? (swx[32] || swy[32]) : (sc[16] || sr[16]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_world_x_out  = wx_r;
  assign out_world_y_out  = wy_r;
  assign out_tile_col_out = tc_r;
  assign out_tile_row_out = tr_r;
  assign out_clipped      = clip_r;

endmodule
`default_nettype wire

@@ design/tgcc_chk.sv @@
`default_nettype none
module tgcc_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_world_x_out,
  input wire logic signed [31:0] out_world_y_out,
  input wire logic signed [15:0] out_tile_col_out,
  input wire logic signed [15:0] out_tile_row_out,
  input wire logic               out_clipped
);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) && $past(rst_n) |->
      out_valid && $stable(out_world_x_out) && $stable(out_tile_col_out))
    else $error("stalled result word changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_world_x_out != 0 || out_world_y_out != 0) |->
      out_tile_col_out == 0 && out_tile_row_out == 0)
    else $error("result word carries both directions");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind tile_grid_coordinate_convert tgcc_chk u_tgcc_chk (.*);
`default_nettype wire
